// ===== hw/rtl/rstg_pkg.sv =====
package rstg_pkg;

    localparam int MAX_RUN_DEFAULT = 64;

    localparam int REFRESH_W  = 20;
    localparam int STEP_W     = 20;
    localparam int COUNT_W    = 7;
    localparam int HTOT_W     = 16;
    localparam int VTOT_W     = 16;
    localparam int CEIL_W     = 20;
    localparam int PCLK_W     = 43;
    localparam int LRATE_W    = 27;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int RATE_DIVISOR = 2000;
    localparam int CLOCK_LIMIT  = 655350000;

    localparam logic [CFG_IDX_W-1:0] CFG_H_TOTAL            = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_V_TOTAL            = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERLACED         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADVERTISED_CEILING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ESTIMATED_CEILING  = 3'd4;

    typedef struct packed {
        logic [REFRESH_W-1:0] start_refresh;
        logic [STEP_W-1:0]    step_size;
        logic [COUNT_W-1:0]   max_count;
    } req_t;

    typedef struct packed {
        logic [REFRESH_W-1:0] refresh_rate;
        logic [PCLK_W-1:0]    dot_clock;
        logic [LRATE_W-1:0]   line_rate;
        logic                 advertised;
        logic                 clock_in_limit;
        logic                 truncated;
        logic                 last;
    } res_t;

endpackage

// ===== hw/rtl/refresh_sweep_timing_generator.sv =====
// a taken request steps through pick, line and pixel multiply, a wait on the line divide,
// pixel divide, a wait on the pixel divide and emit; the ceiling word adds a ceiling pick
// step; each word runs the divide by 2000 twice, six 9-bit reciprocal steps per pass
// busy stays high for the whole run; the receiver cannot stall, results strobe one cycle
// reset clears configuration, sequencer and divider control; no clearing pass
module refresh_sweep_timing_generator #(
    parameter int MAX_RUN = rstg_pkg::MAX_RUN_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            cfg_we,
    input  logic [rstg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rstg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  rstg_pkg::req_t                  request,
    output logic                            result_strobe,
    output rstg_pkg::res_t                  result
);
    import rstg_pkg::*;

    localparam int CNT_W      = $clog2(MAX_RUN + 1);
    localparam int VF_W       = VTOT_W + 1;
    localparam int LNUM_W     = REFRESH_W + VF_W;
    localparam int PNUM_W     = LNUM_W + HTOT_W;
    localparam int DIV_W      = PNUM_W + 1;
    localparam int REM_W      = $clog2(RATE_DIVISOR);
    localparam int DIV_CHUNK  = 9;
    localparam int DIV_STEPS  = DIV_W / DIV_CHUNK;
    localparam int DCNT_W     = $clog2(DIV_STEPS);
    localparam int DIV_PART_W = REM_W + DIV_CHUNK;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W    = 22;
    localparam int PROD_W     = DIV_PART_W + RECIP_W;
    localparam int PC_W       = 4;
    localparam int DIV_ROUND  = RATE_DIVISOR - 1;

    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(RATE_DIVISOR - 1)) / 64'(RATE_DIVISOR));

    localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [PC_W-1:0] STEP_PICK      = 4'd1;
    localparam logic [PC_W-1:0] STEP_MUL_LINE  = 4'd2;
    localparam logic [PC_W-1:0] STEP_MUL_PIX   = 4'd3;
    localparam logic [PC_W-1:0] STEP_WAIT_LINE = 4'd4;
    localparam logic [PC_W-1:0] STEP_DIV_PIX   = 4'd5;
    localparam logic [PC_W-1:0] STEP_WAIT_PIX  = 4'd6;
    localparam logic [PC_W-1:0] STEP_EMIT      = 4'd7;
    localparam logic [PC_W-1:0] STEP_NEXT      = 4'd8;
    localparam logic [PC_W-1:0] STEP_CEIL      = 4'd9;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_PICK_SWEEP,
        OP_PICK_CEIL,
        OP_MUL_LINE,
        OP_MUL_PIX,
        OP_DIV_PIX,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NOT_GO,
        COND_LOOP_END,
        COND_DIV_BUSY,
        COND_FINAL
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    function automatic ctrl_t microcode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            STEP_IDLE:      w = '{OP_LOAD,       COND_NOT_GO,   STEP_IDLE};
            STEP_PICK:      w = '{OP_PICK_SWEEP, COND_LOOP_END, STEP_CEIL};
            STEP_MUL_LINE:  w = '{OP_MUL_LINE,   COND_NONE,     STEP_IDLE};
            STEP_MUL_PIX:   w = '{OP_MUL_PIX,    COND_NONE,     STEP_IDLE};
            STEP_WAIT_LINE: w = '{OP_NOP,        COND_DIV_BUSY, STEP_WAIT_LINE};
            STEP_DIV_PIX:   w = '{OP_DIV_PIX,    COND_NONE,     STEP_IDLE};
            STEP_WAIT_PIX:  w = '{OP_NOP,        COND_DIV_BUSY, STEP_WAIT_PIX};
            STEP_EMIT:      w = '{OP_EMIT,       COND_FINAL,    STEP_IDLE};
            STEP_NEXT:      w = '{OP_NOP,        COND_ALWAYS,   STEP_PICK};
            STEP_CEIL:      w = '{OP_PICK_CEIL,  COND_ALWAYS,   STEP_MUL_LINE};
            default:        w = '{OP_NOP,        COND_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

    // configuration
    logic [HTOT_W-1:0] h_total_reg, h_total_next;
    logic [VTOT_W-1:0] v_total_reg, v_total_next;
    logic              interlaced_reg, interlaced_next;
    logic [CEIL_W-1:0] adv_ceil_reg, adv_ceil_next;
    logic [CEIL_W-1:0] est_ceil_reg, est_ceil_next;

    // sequencer and divider control
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic              strobe_reg, strobe_next;
    logic              div_busy_reg, div_busy_next;
    logic [DCNT_W-1:0] div_cnt_reg, div_cnt_next;

    // datapath
    logic [REFRESH_W:0]   refresh_reg, refresh_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]     limit_reg, limit_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [REFRESH_W-1:0] cand_reg, cand_next;
    logic                 tail_reg, tail_next;
    logic                 trunc_reg, trunc_next;
    logic [LNUM_W-1:0]    line_num_reg, line_num_next;
    logic [PNUM_W-1:0]    pix_num_reg, pix_num_next;
    logic [LRATE_W-1:0]   line_reg, line_next;
    logic [DIV_W-1:0]     div_num_reg, div_num_next;
    logic [REM_W-1:0]     div_rem_reg, div_rem_next;
    res_t                 result_reg, result_next;

    ctrl_t                 ctrl;
    logic                  go;
    logic                  loop_end;
    logic                  final_cand;
    logic                  cond_hit;
    logic [VF_W-1:0]       vf;
    logic [CNT_W-1:0]      limit_sat;
    logic [DIV_PART_W-1:0] div_part;
    logic [PROD_W-1:0]     div_prod;
    logic [DIV_CHUNK-1:0]  div_q;
    logic [DIV_PART_W-1:0] div_left;
    logic                  div_start;
    logic [DIV_W-1:0]      div_operand;

    assign ctrl = microcode(pc_reg);
    assign busy = (pc_reg != STEP_IDLE);
    assign result_strobe = strobe_reg;
    assign result = result_reg;

    // vertical factor 2*v_total + interlaced
    assign vf = {v_total_reg, interlaced_reg};

    assign go = start
        && (request.start_refresh != '0)
        && (request.step_size != '0)
        && (request.max_count != '0)
        && (est_ceil_reg >= request.start_refresh);

    assign limit_sat = (request.max_count > COUNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN)
                                                               : CNT_W'(request.max_count);

    assign loop_end = (refresh_reg > {1'b0, est_ceil_reg})
        || (({1'b0, n_reg} + (CNT_W+1)'(1)) >= {1'b0, limit_reg});

    // a swept word that lands on the ceiling closes the run, as does the ceiling word
    assign final_cand = tail_reg || (cand_reg == est_ceil_reg);

    always_comb
    begin
        case (ctrl.cond)
            COND_NONE:     cond_hit = 1'b0;
            COND_ALWAYS:   cond_hit = 1'b1;
            COND_NOT_GO:   cond_hit = !go;
            COND_LOOP_END: cond_hit = loop_end;
            COND_DIV_BUSY: cond_hit = div_busy_reg;
            COND_FINAL:    cond_hit = final_cand;
            default:       cond_hit = 1'b1;
        endcase
    end

    assign pc_next = cond_hit ? ctrl.target : (pc_reg + PC_W'(1));

    // one quotient digit: partial remainder times reciprocal, then back-multiply
    assign div_part = {div_rem_reg, div_num_reg[DIV_W-1 -: DIV_CHUNK]};
    assign div_prod = PROD_W'(div_part) * PROD_W'(DIV_RECIP);
    assign div_q    = div_prod[RECIP_SHIFT +: DIV_CHUNK];
    assign div_left = div_part - (DIV_PART_W'(div_q) * DIV_PART_W'(RATE_DIVISOR));

    always_comb
    begin
        h_total_next    = h_total_reg;
        v_total_next    = v_total_reg;
        interlaced_next = interlaced_reg;
        adv_ceil_next   = adv_ceil_reg;
        est_ceil_next   = est_ceil_reg;
        refresh_next    = refresh_reg;
        step_next       = step_reg;
        limit_next      = limit_reg;
        n_next          = n_reg;
        cand_next       = cand_reg;
        tail_next       = tail_reg;
        trunc_next      = trunc_reg;
        line_num_next   = line_num_reg;
        pix_num_next    = pix_num_reg;
        line_next       = line_reg;
        result_next     = result_reg;
        strobe_next     = 1'b0;
        div_start       = 1'b0;
        div_operand     = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_H_TOTAL:            h_total_next    = cfg_data[HTOT_W-1:0];
                CFG_V_TOTAL:            v_total_next    = cfg_data[VTOT_W-1:0];
                CFG_INTERLACED:         interlaced_next = cfg_data[0];
                CFG_ADVERTISED_CEILING: adv_ceil_next   = cfg_data[CEIL_W-1:0];
                CFG_ESTIMATED_CEILING:  est_ceil_next   = cfg_data[CEIL_W-1:0];
                default:                ;
            endcase
        end

        case (ctrl.op)
            OP_LOAD:
            begin
                if (go)
                begin
                    refresh_next = {1'b0, request.start_refresh};
                    step_next    = request.step_size;
                    limit_next   = limit_sat;
                    n_next       = '0;
                end
            end
            OP_PICK_SWEEP:
            begin
                cand_next = refresh_reg[REFRESH_W-1:0];
                tail_next = 1'b0;
            end
            OP_PICK_CEIL:
            begin
                cand_next  = est_ceil_reg;
                tail_next  = 1'b1;
                trunc_next = (refresh_reg <= {1'b0, est_ceil_reg});
            end
            OP_MUL_LINE:
            begin
                line_num_next = LNUM_W'(cand_reg) * LNUM_W'(vf);
            end
            OP_MUL_PIX:
            begin
                pix_num_next = PNUM_W'(line_num_reg) * PNUM_W'(h_total_reg);
                div_start    = 1'b1;
                div_operand  = DIV_W'(line_num_reg) + DIV_W'(DIV_ROUND);
            end
            OP_DIV_PIX:
            begin
                line_next   = div_num_reg[LRATE_W-1:0];
                div_start   = 1'b1;
                div_operand = DIV_W'(pix_num_reg) + DIV_W'(DIV_ROUND);
            end
            OP_EMIT:
            begin
                strobe_next                = 1'b1;
                result_next.refresh_rate   = cand_reg;
                result_next.dot_clock      = div_num_reg[PCLK_W-1:0];
                result_next.line_rate      = line_reg;
                result_next.advertised     = (cand_reg <= adv_ceil_reg);
                result_next.clock_in_limit = (div_num_reg <= DIV_W'(CLOCK_LIMIT));
                result_next.truncated      = tail_reg && trunc_reg;
                result_next.last           = final_cand;
                if (!tail_reg)
                begin
                    n_next       = n_reg + CNT_W'(1);
                    refresh_next = refresh_reg + {1'b0, step_reg};
                end
            end
            default: ;
        endcase
    end

    // divide by the rate divisor, one 9-bit digit per cycle, most significant first
    always_comb
    begin
        div_num_next  = div_num_reg;
        div_rem_next  = div_rem_reg;
        div_cnt_next  = div_cnt_reg;
        div_busy_next = div_busy_reg;
        if (div_start)
        begin
            div_num_next  = div_operand;
            div_rem_next  = '0;
            div_cnt_next  = DCNT_W'(DIV_STEPS - 1);
            div_busy_next = 1'b1;
        end
        else if (div_busy_reg)
        begin
            div_num_next = {div_num_reg[DIV_W-DIV_CHUNK-1:0], div_q};
            div_rem_next = div_left[REM_W-1:0];
            if (div_cnt_reg == '0)
            begin
                div_busy_next = 1'b0;
            end
            else
            begin
                div_cnt_next = div_cnt_reg - DCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_total_reg    <= '0;
            v_total_reg    <= '0;
            interlaced_reg <= 1'b0;
            adv_ceil_reg   <= '0;
            est_ceil_reg   <= '0;
            pc_reg         <= STEP_IDLE;
            strobe_reg     <= 1'b0;
            div_busy_reg   <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            h_total_reg    <= h_total_next;
            v_total_reg    <= v_total_next;
            interlaced_reg <= interlaced_next;
            adv_ceil_reg   <= adv_ceil_next;
            est_ceil_reg   <= est_ceil_next;
            pc_reg         <= pc_next;
            strobe_reg     <= strobe_next;
            div_busy_reg   <= div_busy_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        refresh_reg  <= refresh_next;
        step_reg     <= step_next;
        limit_reg    <= limit_next;
        n_reg        <= n_next;
        cand_reg     <= cand_next;
        tail_reg     <= tail_next;
        trunc_reg    <= trunc_next;
        line_num_reg <= line_num_next;
        pix_num_reg  <= pix_num_next;
        line_reg     <= line_next;
        div_num_reg  <= div_num_next;
        div_rem_reg  <= div_rem_next;
        result_reg   <= result_next;
    end

    a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> ($past(pc_reg) == STEP_EMIT))
        else $error("result word without emit step");

    a_div_only_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> ((pc_reg == STEP_WAIT_LINE) || (pc_reg == STEP_WAIT_PIX)))
        else $error("divider running outside a wait step");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |-> !busy)
        else $error("run still busy after last word");

    a_trunc_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last) |-> !result.truncated)
        else $error("truncated set on a word that is not last");

    a_run_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("run began without a start");

endmodule
